[hw/rtl/rem_pkg.sv]
// rem_pkg: shared widths, codes and control structs of the rumble effect mixer
// used by the channel interfaces, the controller, the datapath and the top level
`default_nettype none

package rem_pkg;

   localparam int STR_W    = 16;
   localparam int TIME_W   = 16;
   localparam int CMD_W    = 2;
   localparam int STAT_W   = 2;
   localparam int LIVE_W   = 5;

   localparam logic [STR_W-1:0] FULL_FORCE = 16'h8000;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [CMD_W-1:0] MOTOR_NONE    = 2'd0;
   localparam logic [CMD_W-1:0] MOTOR_START   = 2'd1;
   localparam logic [CMD_W-1:0] MOTOR_RESTART = 2'd2;
   localparam logic [CMD_W-1:0] MOTOR_STOP    = 2'd3;

   localparam logic [STAT_W-1:0] ADD_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ADD_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ADD_NODEV = 2'd2;

   typedef struct packed {
      logic              load;
      logic              store;
      logic              set_status;
      logic [STAT_W-1:0] status;
      logic              rd_en;
      logic              proc_en;
      logic              emit;
   } rem_cmd_type;

   typedef struct packed {
      logic device_present;
      logic idx_live;
      logic out_free;
   } rem_status_type;

endpackage

`default_nettype wire

[hw/rtl/rem_channels.sv]
// rem_channels: valid/ready channel interfaces for request, response and csr write
// depends on rem_pkg for field widths
`default_nettype none

interface rem_req_if
   import rem_pkg::*;
;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [STR_W-1:0]  strength;
   logic [TIME_W-1:0] lifetime;
   logic [TIME_W-1:0] elapsed;

   modport source (output valid, req_type, strength, lifetime, elapsed, input ready);
   modport sink   (input valid, req_type, strength, lifetime, elapsed, output ready);
endinterface

interface rem_rsp_if
   import rem_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  motor_cmd;
   logic [STR_W-1:0]  motor_strength;
   logic [LIVE_W-1:0] live_count;
   logic [STAT_W-1:0] add_status;

   modport source (output valid, motor_cmd, motor_strength, live_count, add_status,
                   input ready);
   modport sink   (input valid, motor_cmd, motor_strength, live_count, add_status,
                   output ready);
endinterface

interface rem_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/rem_ctrl.sv]
// rem_ctrl: sequencer for add scans and tick walks over the effect slots
// depends on rem_pkg; drives rem_datapath through rem_cmd_type
`default_nettype none

module rem_ctrl
   import rem_pkg::*;
#(
   parameter int MAX_EFFECTS = 16,
   localparam int IDX_W = (MAX_EFFECTS > 1) ? $clog2(MAX_EFFECTS) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_type,
   output logic                  req_ready,
   input  rem_status_type        status,
   output rem_cmd_type           cmd,
   output logic [IDX_W-1:0]      rd_idx,
   output logic [IDX_W-1:0]      proc_idx
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ADD   = 3'd1;
   localparam logic [2:0] ST_TICK  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_EFFECTS - 1);

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0] proc_idx_ff;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rd_idx    = idx_ff;
   assign proc_idx  = proc_idx_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      proc_valid_in = 1'b0;
      cmd           = '0;
      cmd.proc_en   = proc_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = (req_type == REQ_TICK) ? ST_TICK : ST_ADD;
            end
         end
         ST_ADD: begin
            if (!status.device_present) begin
               cmd.set_status = 1'b1;
               cmd.status     = ADD_NODEV;
               state_in       = ST_DONE;
            end else if (!status.idx_live) begin
               cmd.store = 1'b1;
               state_in  = ST_DONE;
            end else if (idx_ff == LAST_IDX) begin
               cmd.set_status = 1'b1;
               cmd.status     = ADD_FULL;
               state_in       = ST_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_TICK: begin
            cmd.rd_en     = 1'b1;
            proc_valid_in = 1'b1;
            idx_in        = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         proc_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         proc_valid_ff <= proc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff <= idx_ff;
   end

`ifndef SYNTHESIS
   a_emit_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result emitted while output register still full");

   a_store_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (!status.idx_live && status.device_present))
      else $error("store into a live slot or without device");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_ADD || state_ff == ST_TICK))
      else $error("accepted item did not start an add or a tick");
`endif

endmodule

`default_nettype wire

[hw/rtl/rem_datapath.sv]
// rem_datapath: slot memories, live bits, strength accumulator, motor state and
// response register; depends on rem_pkg, sequenced by rem_ctrl
`default_nettype none

module rem_datapath
   import rem_pkg::*;
#(
   parameter int MAX_EFFECTS = 16,
   localparam int IDX_W = (MAX_EFFECTS > 1) ? $clog2(MAX_EFFECTS) : 1,
   localparam int CNT_W = $clog2(MAX_EFFECTS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  rem_cmd_type            cmd,
   input  wire logic [IDX_W-1:0]  rd_idx,
   input  wire logic [IDX_W-1:0]  proc_idx,
   output rem_status_type         status,
   input  wire logic              req_type,
   input  wire logic [STR_W-1:0]  req_strength,
   input  wire logic [TIME_W-1:0] req_lifetime,
   input  wire logic [TIME_W-1:0] req_elapsed,
   input  wire logic              csr_we,
   input  wire logic              csr_data,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [CMD_W-1:0]       rsp_motor_cmd,
   output logic [STR_W-1:0]       rsp_motor_strength,
   output logic [LIVE_W-1:0]      rsp_live_count,
   output logic [STAT_W-1:0]      rsp_add_status
);

   logic [STR_W-1:0]  slot_strength_ff [MAX_EFFECTS];
   logic [TIME_W-1:0] slot_time_ff [MAX_EFFECTS];

   logic              type_ff;
   logic [STR_W-1:0]  strength_ff;
   logic [TIME_W-1:0] lifetime_ff;
   logic [TIME_W-1:0] elapsed_ff;
   logic [STR_W-1:0]  rd_str_ff;
   logic [TIME_W-1:0] rd_time_ff;

   logic [MAX_EFFECTS-1:0] live_ff, live_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [STR_W-1:0]       sum_ff, sum_in;
   logic [STAT_W-1:0]      add_status_ff, add_status_in;
   logic                   device_ff, device_in;
   logic                   motor_on_ff, motor_on_in;
   logic [STR_W-1:0]       motor_last_ff, motor_last_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CMD_W-1:0]       rsp_cmd_ff, rsp_cmd_in;
   logic [STR_W-1:0]       rsp_str_ff, rsp_str_in;
   logic [LIVE_W-1:0]      rsp_count_ff;
   logic [STAT_W-1:0]      rsp_status_ff;

   logic                   proc_live;
   logic [TIME_W-1:0]      time_left;
   logic                   expire;
   logic                   keep;
   logic [STR_W:0]         sum_wide;
   logic                   any_live;
   logic [CNT_W+LIVE_W-1:0] count_ext;
   logic                   time_we;
   logic [IDX_W-1:0]       time_addr;
   logic [TIME_W-1:0]      time_wdata;

   assign proc_live  = live_ff[proc_idx];
   assign time_left  = (rd_time_ff > elapsed_ff) ? (rd_time_ff - elapsed_ff) : '0;
   assign expire     = cmd.proc_en && proc_live && (time_left == '0);
   assign keep       = cmd.proc_en && proc_live && (time_left != '0);
   assign sum_wide   = {1'b0, sum_ff} + {1'b0, rd_str_ff};
   assign any_live   = (count_ff != '0);
   assign count_ext  = {{LIVE_W{1'b0}}, count_ff};

   assign time_we    = cmd.store || (cmd.proc_en && proc_live);
   assign time_addr  = cmd.store ? rd_idx : proc_idx;
   assign time_wdata = cmd.store ? lifetime_ff : time_left;

   assign status.device_present = device_ff;
   assign status.idx_live       = live_ff[rd_idx];
   assign status.out_free       = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motor_cmd      = rsp_cmd_ff;
   assign rsp_motor_strength = rsp_str_ff;
   assign rsp_live_count     = rsp_count_ff;
   assign rsp_add_status     = rsp_status_ff;

   // slot memories
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         slot_strength_ff[rd_idx] <= strength_ff;
      end
      if (cmd.rd_en) begin
         rd_str_ff <= slot_strength_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (time_we) begin
         slot_time_ff[time_addr] <= time_wdata;
      end
      if (cmd.rd_en) begin
         rd_time_ff <= slot_time_ff[rd_idx];
      end
   end

   always_comb begin
      live_in       = live_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      add_status_in = add_status_ff;
      device_in     = csr_we ? csr_data : device_ff;
      motor_on_in   = motor_on_ff;
      motor_last_in = motor_last_ff;
      rsp_cmd_in    = MOTOR_NONE;
      rsp_str_in    = '0;

      if (cmd.load) begin
         sum_in        = '0;
         add_status_in = ADD_OK;
      end
      if (cmd.set_status) begin
         add_status_in = cmd.status;
      end
      if (cmd.store) begin
         live_in[rd_idx] = 1'b1;
         count_in        = count_ff + CNT_W'(1);
      end
      if (expire) begin
         live_in[proc_idx] = 1'b0;
         count_in          = count_ff - CNT_W'(1);
      end
      if (keep) begin
         sum_in = (sum_wide > {1'b0, FULL_FORCE}) ? FULL_FORCE : sum_wide[STR_W-1:0];
      end

      // motor decision after the walk
      if ((type_ff == REQ_TICK) && device_ff) begin
         if (any_live && motor_on_ff) begin
            if (sum_ff != motor_last_ff) begin
               rsp_cmd_in = MOTOR_RESTART;
               rsp_str_in = sum_ff;
            end
         end else if (any_live) begin
            rsp_cmd_in = MOTOR_START;
            rsp_str_in = sum_ff;
         end else if (motor_on_ff) begin
            rsp_cmd_in = MOTOR_STOP;
         end
         if (cmd.emit) begin
            motor_on_in   = any_live;
            motor_last_in = any_live ? sum_ff : '0;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff       <= '0;
         count_ff      <= '0;
         device_ff     <= 1'b1;
         motor_on_ff   <= 1'b0;
         motor_last_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         live_ff       <= live_in;
         count_ff      <= count_in;
         device_ff     <= device_in;
         motor_on_ff   <= motor_on_in;
         motor_last_ff <= motor_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff        <= sum_in;
      add_status_ff <= add_status_in;
      if (cmd.load) begin
         type_ff     <= req_type;
         strength_ff <= req_strength;
         lifetime_ff <= req_lifetime;
         elapsed_ff  <= req_elapsed;
      end
      if (cmd.emit) begin
         rsp_cmd_ff    <= rsp_cmd_in;
         rsp_str_ff    <= rsp_str_in;
         rsp_count_ff  <= count_ext[LIVE_W-1:0];
         rsp_status_ff <= add_status_ff;
      end
   end

`ifndef SYNTHESIS
   a_count_matches_live: assert property (@(posedge clock) disable iff (reset)
      $countones(live_ff) == int'(count_ff))
      else $error("live count out of step with live bits");

   a_motor_off_clears_strength: assert property (@(posedge clock) disable iff (reset)
      !motor_on_ff |-> (motor_last_ff == '0))
      else $error("motor off but last strength nonzero");

   a_no_strength_without_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_cmd_ff == MOTOR_NONE || rsp_cmd_ff == MOTOR_STOP))
         |-> (rsp_str_ff == '0))
      else $error("strength reported without a start or restart");
`endif

endmodule

`default_nettype wire

[hw/rtl/rumble_effect_mixer.sv]
// rumble_effect_mixer: top level, joins rem_ctrl and rem_datapath to the channels
// depends on rem_pkg and the interfaces in rem_channels
//
// Usage: items arrive on req. An add (req_type 0) stores strength and lifetime
// in a free slot; a tick (req_type 1) ages every live slot by elapsed, frees
// expired slots, sums the remaining strengths (saturated at 1.0 in Q1.15) and
// produces a start, restart, stop or no motor command. Every item gives exactly
// one item on rsp. csr carries the device_present bit and is always ready; write
// it only while no item is in flight.
// Timing: an add's time to result is set by the slot scan, which stops at the
// first free slot; a tick's is set by the walk of one slot per cycle through the
// single read port of the slot memories. A new item is accepted in the cycle
// after the previous result is loaded.
// Reset (synchronous) frees all slots, turns the motor state off and sets
// device_present. The result sits in an output register: a stalled receiver
// holds it, the next item is still accepted and worked, and waits to be loaded.
`default_nettype none

module rumble_effect_mixer
   import rem_pkg::*;
#(
   parameter int MAX_EFFECTS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   rem_req_if.sink   req,
   rem_rsp_if.source rsp,
   rem_csr_if.sink   csr
);

   localparam int IDX_W = (MAX_EFFECTS > 1) ? $clog2(MAX_EFFECTS) : 1;

   rem_cmd_type      cmd;
   rem_status_type   status;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] proc_idx;

   assign csr.ready = 1'b1;

   rem_ctrl #(
      .MAX_EFFECTS (MAX_EFFECTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_type  (req.req_type),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd),
      .rd_idx    (rd_idx),
      .proc_idx  (proc_idx)
   );

   rem_datapath #(
      .MAX_EFFECTS (MAX_EFFECTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .rd_idx             (rd_idx),
      .proc_idx           (proc_idx),
      .status             (status),
      .req_type           (req.req_type),
      .req_strength       (req.strength),
      .req_lifetime       (req.lifetime),
      .req_elapsed        (req.elapsed),
      .csr_we             (csr.valid),
      .csr_data           (csr.data),
      .rsp_ready          (rsp.ready),
      .rsp_valid          (rsp.valid),
      .rsp_motor_cmd      (rsp.motor_cmd),
      .rsp_motor_strength (rsp.motor_strength),
      .rsp_live_count     (rsp.live_count),
      .rsp_add_status     (rsp.add_status)
   );

endmodule

`default_nettype wire

[tb/sv/rumble_effect_mixer_tb.sv]
// rumble_effect_mixer_tb: self-checking bench for the rumble effect mixer, a directed
// table then random effect/tick sequences checked against a cycle-free behavioral mixer
// depends on rem_pkg, the channel interfaces in rem_channels and the rumble_effect_mixer top
module rumble_effect_mixer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rem_pkg::*;

   localparam int SLOTS       = 16;
   localparam int ITEM_TARGET = 700;

   typedef struct packed {
      logic              req_type;
      logic [STR_W-1:0]  strength;
      logic [TIME_W-1:0] lifetime;
      logic [TIME_W-1:0] elapsed;
   } mix_item_type;

   typedef struct packed {
      logic [CMD_W-1:0]  motor_cmd;
      logic [STR_W-1:0]  motor_strength;
      logic [LIVE_W-1:0] live_count;
      logic [STAT_W-1:0] add_status;
   } mix_result_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type   kind;
      mix_item_type   item;
      logic           csr_value;
      bit             fixed;
      mix_result_type result;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rem_req_if req_bus ();
   rem_rsp_if rsp_bus ();
   rem_csr_if csr_bus ();

   rumble_effect_mixer #(
      .MAX_EFFECTS(SLOTS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus),
      .csr  (csr_bus)
   );

   always #1 clock = ~clock;

   // behavioral mixer state
   logic [STR_W-1:0]  eff_strength  [SLOTS];
   logic [TIME_W-1:0] eff_time_left [SLOTS];
   logic              eff_live      [SLOTS];
   logic              motor_running = 1'b0;
   logic [STR_W-1:0]  motor_level   = '0;
   logic              dev_present   = 1'b1;

   mix_result_type pending_results[$];
   row_type        dir_rows[$];
   int             items_sent = 0;
   int             burst_left = 0;
   int             error_count = 0;

   function automatic mix_result_type mix_predict(mix_item_type it);
      mix_result_type r;
      int          free_slot;
      int unsigned total;
      bit          any;
      int          n;
      r = '0;
      if (it.req_type == REQ_ADD) begin
         if (!dev_present) begin
            r.add_status = ADD_NODEV;
         end else begin
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (!eff_live[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot < 0) begin
               r.add_status = ADD_FULL;
            end else begin
               eff_strength[free_slot]  = it.strength;
               eff_time_left[free_slot] = it.lifetime;
               eff_live[free_slot]      = 1'b1;
            end
         end
      end else begin
         total = 0;
         any   = 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            if (eff_live[i]) begin
               if (eff_time_left[i] > it.elapsed) eff_time_left[i] = eff_time_left[i] - it.elapsed;
               else eff_time_left[i] = '0;
               if (eff_time_left[i] == '0) begin
                  eff_live[i] = 1'b0;
               end else begin
                  total += eff_strength[i];
                  any = 1'b1;
               end
            end
         end
         if (total > FULL_FORCE) total = FULL_FORCE;
         if (dev_present) begin
            if (any && motor_running) begin
               if (total[STR_W-1:0] != motor_level) begin
                  r.motor_cmd      = MOTOR_RESTART;
                  r.motor_strength = total[STR_W-1:0];
               end
            end else if (any) begin
               r.motor_cmd      = MOTOR_START;
               r.motor_strength = total[STR_W-1:0];
            end else if (motor_running) begin
               r.motor_cmd = MOTOR_STOP;
            end
            motor_running = any;
            motor_level   = any ? total[STR_W-1:0] : '0;
         end
      end
      n = 0;
      for (int i = 0; i < SLOTS; i++) if (eff_live[i]) n++;
      r.live_count = n[LIVE_W-1:0];
      return r;
   endfunction

   function automatic void plan_item(logic kind_type, int str, int life, int el,
                                     bit chk = 1'b0, logic [CMD_W-1:0] cmd = MOTOR_NONE,
                                     int live = 0, logic [STAT_W-1:0] stat = ADD_OK);
      row_type row;
      row.kind                  = ROW_ITEM;
      row.item.req_type         = kind_type;
      row.item.strength         = str[STR_W-1:0];
      row.item.lifetime         = life[TIME_W-1:0];
      row.item.elapsed          = el[TIME_W-1:0];
      row.csr_value             = 1'b0;
      row.fixed                 = chk;
      row.result.motor_cmd      = cmd;
      row.result.motor_strength = '0;
      row.result.live_count     = live[LIVE_W-1:0];
      row.result.add_status     = stat;
      dir_rows.push_back(row);
   endfunction

   function automatic void plan_csr(logic v);
      row_type row;
      row.kind      = ROW_CSR;
      row.item      = '0;
      row.csr_value = v;
      row.fixed     = 1'b0;
      row.result    = '0;
      dir_rows.push_back(row);
   endfunction

   function automatic mix_item_type random_add(bit wide_str, bit long_life);
      mix_item_type it;
      it.req_type = REQ_ADD;
      it.elapsed  = TIME_W'($urandom);
      case ($urandom_range(0, 9))
         0:       it.strength = FULL_FORCE;
         1:       it.strength = '0;
         default: it.strength = wide_str ? STR_W'($urandom) : STR_W'($urandom_range(0, 12000));
      endcase
      if (long_life)      it.lifetime = TIME_W'($urandom_range(1000, 65535));
      else if (wide_str)  it.lifetime = TIME_W'($urandom);
      else                it.lifetime = TIME_W'($urandom_range(0, 300));
      return it;
   endfunction

   function automatic mix_item_type random_tick(bit wide);
      mix_item_type it;
      it.req_type = REQ_TICK;
      it.strength = STR_W'($urandom);
      it.lifetime = TIME_W'($urandom);
      it.elapsed  = wide ? TIME_W'($urandom) : TIME_W'($urandom_range(0, 120));
      return it;
   endfunction

   function automatic mix_item_type random_any();
      mix_item_type it;
      it.req_type = $urandom_range(0, 1) ? REQ_TICK : REQ_ADD;
      it.strength = STR_W'($urandom);
      it.lifetime = TIME_W'($urandom);
      it.elapsed  = TIME_W'($urandom);
      return it;
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
      error_count++;
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 40);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
      end
   endtask

   task automatic drive_item(mix_item_type it, bit use_fixed, mix_result_type fixed_res);
      mix_result_type r;
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= it.req_type;
      req_bus.strength <= it.strength;
      req_bus.lifetime <= it.lifetime;
      req_bus.elapsed  <= it.elapsed;
      do @(posedge clock); while (!req_bus.ready);
      r = mix_predict(it);
      pending_results.push_back(use_fixed ? fixed_res : r);
      items_sent++;
      pace_sender();
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
   endtask

   task automatic write_device(logic v);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      dev_present = v;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_phase(int quota);
      int kind;
      int n;
      while (items_sent < quota) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            n = $urandom_range(1, 6);
            repeat (n) drive_item(random_add($urandom_range(0, 5) == 0, 1'b0), 1'b0, '0);
            n = $urandom_range(1, 4);
            repeat (n) drive_item(random_tick($urandom_range(0, 7) == 0), 1'b0, '0);
         end else if (kind == 6) begin
            n = $urandom_range(17, 20);
            repeat (n) drive_item(random_add(1'b0, 1'b1), 1'b0, '0);
         end else if (kind == 7) begin
            drive_item(random_tick(1'b0) | mix_item_type'({TIME_W{1'b1}}), 1'b0, '0);
         end else begin
            n = $urandom_range(1, 5);
            repeat (n) drive_item(random_any(), 1'b0, '0);
         end
      end
   endtask

   // receiver: checks each item and stalls on its own pattern
   initial begin
      mix_result_type   want;
      int               hold_left;
      int               mode;
      int               mode_left;
      int               pat_idx;
      int               seen;
      logic [15:0]      stall_pattern;
      hold_left     = 0;
      mode          = 0;
      mode_left     = 0;
      pat_idx       = 0;
      seen          = 0;
      stall_pattern = 16'b1101_0110_0011_1011;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready && !reset) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected item, motor_cmd", 0, rsp_bus.motor_cmd);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.motor_cmd !== want.motor_cmd)
                  report_mismatch("motor_cmd", want.motor_cmd, rsp_bus.motor_cmd);
               if (rsp_bus.motor_strength !== want.motor_strength)
                  report_mismatch("motor_strength", want.motor_strength, rsp_bus.motor_strength);
               if (rsp_bus.live_count !== want.live_count)
                  report_mismatch("live_count", want.live_count, rsp_bus.live_count);
               if (rsp_bus.add_status !== want.add_status)
                  report_mismatch("add_status", want.add_status, rsp_bus.add_status);
            end
            seen++;
            if (seen == 100 || seen == 450) hold_left = 400;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: begin
                  rsp_bus.ready <= stall_pattern[pat_idx];
                  pat_idx = (pat_idx + 1) % 16;
               end
            endcase
         end
      end
   end

   // stimulus
   initial begin
      for (int i = 0; i < SLOTS; i++) eff_live[i] = 1'b0;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_ADD;
      req_bus.strength = '0;
      req_bus.lifetime = '0;
      req_bus.elapsed  = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.data     = 1'b1;

      plan_item(REQ_TICK, 0, 0, 0, 1'b1, MOTOR_NONE, 0, ADD_OK);
      plan_item(REQ_ADD, 32768, 65535, 0, 1'b1, MOTOR_NONE, 1, ADD_OK);
      plan_item(REQ_ADD, 0, 0, 0, 1'b1, MOTOR_NONE, 2, ADD_OK);
      plan_item(REQ_TICK, 0, 0, 0);
      plan_item(REQ_ADD, 65535, 10, 0);
      plan_item(REQ_TICK, 0, 0, 1);
      plan_item(REQ_TICK, 0, 0, 65535, 1'b1, MOTOR_STOP, 0, ADD_OK);
      plan_item(REQ_ADD, 0, 5, 0);
      plan_item(REQ_TICK, 0, 0, 0);
      plan_item(REQ_ADD, 100, 100, 0);
      plan_item(REQ_TICK, 0, 0, 1);
      plan_csr(1'b0);
      plan_item(REQ_ADD, 1234, 50, 0, 1'b1, MOTOR_NONE, 2, ADD_NODEV);
      plan_item(REQ_TICK, 0, 0, 4);
      plan_item(REQ_TICK, 0, 0, 65535);
      plan_csr(1'b1);
      plan_item(REQ_TICK, 0, 0, 0, 1'b1, MOTOR_STOP, 0, ADD_OK);
      plan_item(REQ_ADD, 65535, 65535, 65535);
      plan_item(REQ_ADD, 16'h5555, 16'haaaa, 16'h5555);
      plan_item(REQ_ADD, 16'haaaa, 16'h5555, 16'haaaa);
      plan_item(REQ_TICK, 16'h5555, 16'haaaa, 16'haaaa);
      plan_item(REQ_TICK, 16'hffff, 16'hffff, 16'hffff);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) write_device(dir_rows[i].csr_value);
         else drive_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].result);
      end

      write_device(1'b1);
      run_phase(400);
      write_device(1'b0);
      run_phase(490);
      write_device(1'b1);
      run_phase(ITEM_TARGET);
      wait_idle();

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
